// ----- sv/lhpc_pkg.sv -----
// Shared types and constants for the latency histogram block.
// Holds the microcode word layout, the step program and the register indexes.
// No dependencies.
package lhpc_pkg;

    // fixed field widths
    localparam int unsigned IDX_W       = 6;
    localparam int unsigned SCNT_W      = 32;
    localparam int unsigned OUT_CNT_W   = 32;
    localparam int unsigned TIME_W      = 16;
    localparam int unsigned IN_TDATA_W  = 16;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned CFG_IDX_W   = 2;
    localparam int unsigned CFG_DATA_W  = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIN_LIMIT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOG_THRESHOLD = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DUMP_CUM      = 2'd2;

    // configuration reset values
    localparam logic [IDX_W-1:0]  BIN_LIMIT_RST     = 6'd63;
    localparam logic [SCNT_W-1:0] LOG_THRESHOLD_RST = 32'd1000;

    // input op codes and output kinds
    localparam logic OP_SAMPLE   = 1'b0;
    localparam logic OP_DUMP     = 1'b1;
    localparam logic KIND_NOTICE = 1'b0;
    localparam logic KIND_RECORD = 1'b1;

    // program steps
    typedef enum logic [2:0] {
        ST_FETCH = 3'd0,
        ST_SUPD  = 3'd1,
        ST_NOTE  = 3'd2,
        ST_DCHK  = 3'd3,
        ST_DRD   = 3'd4,
        ST_DTST  = 3'd5,
        ST_DEND  = 3'd6
    } step_t;

    // table read address source
    typedef enum logic [1:0] {
        RD_NONE,
        RD_INPUT,
        RD_WALK
    } rd_src_t;

    // datapath action of a step
    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_SAMPLE_UPD,
        ACT_NOTICE,
        ACT_WALK_INIT,
        ACT_WALK_STEP,
        ACT_PEND,
        ACT_FINISH
    } act_t;

    // branch condition of a step
    typedef enum logic [2:0] {
        C_NEXT,
        C_ALWAYS,
        C_DUMP,
        C_CNT_ZERO,
        C_WALK_DONE
    } cond_t;

    typedef struct packed {
        logic    accept;
        rd_src_t rd_src;
        act_t    act;
        cond_t   cond;
        step_t   target;
    } ucode_t;

    // status fed back from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic in_dump;
        logic cnt_zero;
        logic walk_done;
        logic emit_req;
        logic out_free;
    } seq_stat_t;

    // control store
    function automatic ucode_t ucode_rom(input step_t st);
        ucode_t w;
        w = '{accept: 1'b0, rd_src: RD_NONE, act: ACT_NONE, cond: C_ALWAYS,
              target: ST_FETCH};
        unique case (st)
            ST_FETCH: w = '{1'b1, RD_INPUT, ACT_NONE,       C_DUMP,      ST_DCHK};
            ST_SUPD:  w = '{1'b0, RD_NONE,  ACT_SAMPLE_UPD, C_NEXT,      ST_FETCH};
            ST_NOTE:  w = '{1'b0, RD_NONE,  ACT_NOTICE,     C_ALWAYS,    ST_FETCH};
            ST_DCHK:  w = '{1'b0, RD_NONE,  ACT_WALK_INIT,  C_CNT_ZERO,  ST_FETCH};
            ST_DRD:   w = '{1'b0, RD_WALK,  ACT_WALK_STEP,  C_WALK_DONE, ST_DEND};
            ST_DTST:  w = '{1'b0, RD_NONE,  ACT_PEND,       C_ALWAYS,    ST_DRD};
            ST_DEND:  w = '{1'b0, RD_NONE,  ACT_FINISH,     C_ALWAYS,    ST_FETCH};
            default:  w = '{1'b0, RD_NONE,  ACT_NONE,       C_ALWAYS,    ST_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ----- sv/lhpc_seq.sv -----
// Microcode sequencer: step counter, control store lookup and branch logic.
// Depends on lhpc_pkg for the control word, step and status types.
module lhpc_seq (
    input  logic                clk,
    input  logic                rst_n,
    input  lhpc_pkg::seq_stat_t stat,
    output lhpc_pkg::ucode_t    ctrl,
    output logic                go
);
    import lhpc_pkg::*;

    step_t pc_reg;
    step_t pc_next;

    // control word of the current step
    always_comb
    begin
        ctrl = ucode_rom(pc_reg);
    end

    // a step holds while it waits for an input beat or a free output slot
    always_comb
    begin
        go = !((ctrl.accept && !stat.in_valid) || (stat.emit_req && !stat.out_free));
    end

    // next step
    always_comb
    begin
        pc_next = pc_reg;
        if (go)
        begin
            unique case (ctrl.cond)
                C_NEXT:      pc_next = step_t'(pc_reg + 3'd1);
                C_ALWAYS:    pc_next = ctrl.target;
                C_DUMP:      pc_next = stat.in_dump ? ctrl.target : step_t'(pc_reg + 3'd1);
                C_CNT_ZERO:  pc_next = stat.cnt_zero ? ctrl.target : step_t'(pc_reg + 3'd1);
                C_WALK_DONE: pc_next = stat.walk_done ? ctrl.target : step_t'(pc_reg + 3'd1);
                default:     pc_next = ST_FETCH;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg <= ST_FETCH;
        end
        else
        begin
            pc_reg <= pc_next;
        end
    end

    // a dump always ends at the finish step or skips straight back to fetch
    a_fetch_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == ST_DEND && go) |=> (pc_reg == ST_FETCH))
        else $error("sequencer did not return to fetch after finish");

    // sample update always goes on to the notice step
    a_note_after_upd: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == ST_SUPD) |=> (pc_reg == ST_NOTE))
        else $error("sample update not followed by notice step");

    // the fetch step only leaves on an input beat
    a_fetch_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (pc_reg == ST_FETCH && !stat.in_valid) |=> (pc_reg == ST_FETCH))
        else $error("fetch left without an input beat");

endmodule

// ----- sv/latency_histogram_periodic_cumulative.sv -----
// Latency histogram with periodic and cumulative tables, min/max bin tracking.
// A sample runs a table read, a read-modify-write and a notice step. A dump
// runs a check step, a read and a test step per bin in the walked min..max
// range, a last read and a finish step; an empty dump (no samples this period)
// returns to fetch after the check. The order follows from the single read
// port of each table memory walked by the microcode sequencer; a held result
// stalls until taken. Reset clears both tables at once through per-bin valid
// bits, so no clearing pass is needed. Depends on lhpc_pkg and lhpc_seq.
module latency_histogram_periodic_cumulative #(
    parameter int unsigned NUM_BINS    = 64,
    parameter int unsigned COUNT_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // input stream
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [lhpc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [15:0] sample_time
    input  logic                                 s_axis_tuser,  // [0] op
    // result stream
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [lhpc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [5:0] bin_index,
                                                                // [37:6] bin_count
    output logic                                 m_axis_tuser,  // [0] kind
    output logic                                 m_axis_tlast,  // last
    // configuration writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [lhpc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [lhpc_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import lhpc_pkg::*;

    localparam int unsigned BIN_W = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam logic [IDX_W-1:0] TOP_MAX = IDX_W'(NUM_BINS - 1);
    localparam logic [BIN_W-1:0] BIN_TOP = BIN_W'(NUM_BINS - 1);
    localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;
    localparam logic [SCNT_W-1:0] SCNT_MAX = '1;

    // sequencer
    ucode_t    ctrl;
    seq_stat_t stat;
    logic      go;

    // configuration
    logic [IDX_W-1:0]  bin_limit_reg;
    logic [SCNT_W-1:0] log_thresh_reg;
    logic              dump_cum_reg;

    // tables
    logic [COUNT_WIDTH-1:0] per_mem [NUM_BINS];
    logic [COUNT_WIDTH-1:0] tot_mem [NUM_BINS];
    logic [NUM_BINS-1:0]    per_vld_reg;
    logic [NUM_BINS-1:0]    tot_vld_reg;
    logic [COUNT_WIDTH-1:0] per_rd_reg;
    logic [COUNT_WIDTH-1:0] tot_rd_reg;
    logic                   per_rdv_reg;
    logic                   tot_rdv_reg;
    logic                   rd_en;
    logic [BIN_W-1:0]       rd_addr;

    // bin tracking and counters
    logic [BIN_W-1:0]  per_min_reg;
    logic [BIN_W-1:0]  per_max_reg;
    logic [BIN_W-1:0]  tot_min_reg;
    logic [BIN_W-1:0]  tot_max_reg;
    logic [SCNT_W-1:0] smp_cnt_reg;
    logic [SCNT_W-1:0] smp_cnt_inc;
    logic              notice_reg;
    logic [BIN_W-1:0]  samp_bin_reg;

    // walk state
    logic [BIN_W:0]    walk_idx_reg;
    logic [BIN_W-1:0]  walk_hi_reg;
    logic [BIN_W-1:0]  rd_idx_reg;
    logic              walk_done;

    // pending record (held back until the next nonzero bin shows it is not last)
    logic                 pend_vld_reg;
    logic [BIN_W-1:0]     pend_idx_reg;
    logic [OUT_CNT_W-1:0] pend_cnt_reg;

    // output register
    logic                 out_vld_reg;
    logic                 out_kind_reg;
    logic [IDX_W-1:0]     out_idx_reg;
    logic [OUT_CNT_W-1:0] out_cnt_reg;
    logic                 out_last_reg;
    logic                 out_free;

    // combinational helpers
    logic [IDX_W-1:0]       lim6;
    logic [BIN_W-1:0]       top_bin;
    logic [IDX_W-1:0]       in_bin6;
    logic [BIN_W-1:0]       in_bin;
    logic [COUNT_WIDTH-1:0] per_val;
    logic [COUNT_WIDTH-1:0] tot_val;
    logic [COUNT_WIDTH-1:0] per_inc;
    logic [COUNT_WIDTH-1:0] tot_inc;
    logic [COUNT_WIDTH-1:0] sel_val;
    logic                   sel_nz;
    logic                   do_upd;
    logic                   do_finish;
    logic                   emit_req;

    lhpc_seq u_seq (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .ctrl  (ctrl),
        .go    (go)
    );

    // handshake ports
    assign s_axis_tready = ctrl.accept;
    assign cfg_ready     = 1'b1;
    assign out_free      = !out_vld_reg || m_axis_tready;

    // effective overflow bin and input clamp
    always_comb
    begin
        lim6    = (bin_limit_reg > TOP_MAX) ? TOP_MAX : bin_limit_reg;
        top_bin = lim6[BIN_W-1:0];
        in_bin6 = (s_axis_tdata[TIME_W-1:0] >= TIME_W'(lim6)) ? lim6
                                                               : s_axis_tdata[IDX_W-1:0];
        in_bin  = in_bin6[BIN_W-1:0];
    end

    // table values seen through valid bits, saturating increments
    always_comb
    begin
        per_val = per_rdv_reg ? per_rd_reg : '0;
        tot_val = tot_rdv_reg ? tot_rd_reg : '0;
        per_inc = (per_val == COUNT_MAX) ? per_val : per_val + 1'b1;
        tot_inc = (tot_val == COUNT_MAX) ? tot_val : tot_val + 1'b1;
        sel_val = dump_cum_reg ? tot_val : per_val;
        sel_nz  = (sel_val != '0);
        smp_cnt_inc = (smp_cnt_reg == SCNT_MAX) ? smp_cnt_reg : smp_cnt_reg + 1'b1;
    end

    // read address select
    always_comb
    begin
        rd_en   = 1'b0;
        rd_addr = in_bin;
        unique case (ctrl.rd_src)
            RD_INPUT:
            begin
                rd_en   = 1'b1;
                rd_addr = in_bin;
            end
            RD_WALK:
            begin
                rd_en   = 1'b1;
                rd_addr = walk_idx_reg[BIN_W-1:0];
            end
            default:
            begin
                rd_en   = 1'b0;
                rd_addr = in_bin;
            end
        endcase
    end

    // step qualifiers and sequencer status
    always_comb
    begin
        walk_done = (walk_idx_reg > {1'b0, walk_hi_reg});
        do_upd    = go && (ctrl.act == ACT_SAMPLE_UPD);
        do_finish = go && (ctrl.act == ACT_FINISH);
        unique case (ctrl.act)
            ACT_NOTICE: emit_req = notice_reg;
            ACT_PEND:   emit_req = sel_nz && pend_vld_reg;
            ACT_FINISH: emit_req = pend_vld_reg;
            default:    emit_req = 1'b0;
        endcase
        stat.in_valid  = s_axis_tvalid;
        stat.in_dump   = (s_axis_tuser == OP_DUMP);
        stat.cnt_zero  = (smp_cnt_reg == '0);
        stat.walk_done = walk_done;
        stat.emit_req  = emit_req;
        stat.out_free  = out_free;
    end

    // table memories
    always_ff @(posedge clk)
    begin
        if (do_upd)
        begin
            per_mem[samp_bin_reg] <= per_inc;
            tot_mem[samp_bin_reg] <= tot_inc;
        end
        if (rd_en)
        begin
            per_rd_reg <= per_mem[rd_addr];
            tot_rd_reg <= tot_mem[rd_addr];
        end
    end

    // per-bin valid bits: reset and period clear empty a table at once
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            per_vld_reg <= '0;
            tot_vld_reg <= '0;
            per_rdv_reg <= 1'b0;
            tot_rdv_reg <= 1'b0;
        end
        else
        begin
            if (rd_en)
            begin
                per_rdv_reg <= per_vld_reg[rd_addr];
                tot_rdv_reg <= tot_vld_reg[rd_addr];
            end
            if (do_finish)
            begin
                per_vld_reg <= '0;
            end
            else if (do_upd)
            begin
                per_vld_reg[samp_bin_reg] <= 1'b1;
            end
            if (do_upd)
            begin
                tot_vld_reg[samp_bin_reg] <= 1'b1;
            end
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bin_limit_reg  <= BIN_LIMIT_RST;
            log_thresh_reg <= LOG_THRESHOLD_RST;
            dump_cum_reg   <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BIN_LIMIT:     bin_limit_reg  <= cfg_data[IDX_W-1:0];
                CFG_LOG_THRESHOLD: log_thresh_reg <= cfg_data[SCNT_W-1:0];
                CFG_DUMP_CUM:      dump_cum_reg   <= cfg_data[0];
                default:           ;
            endcase
        end
    end

    // sample path: latch bin, update min/max and counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            samp_bin_reg <= '0;
            per_min_reg  <= BIN_TOP;
            per_max_reg  <= '0;
            tot_min_reg  <= BIN_TOP;
            tot_max_reg  <= '0;
            smp_cnt_reg  <= '0;
            notice_reg   <= 1'b0;
        end
        else
        begin
            if (go && ctrl.accept)
            begin
                samp_bin_reg <= in_bin;
            end
            if (do_upd)
            begin
                if (samp_bin_reg < per_min_reg)
                begin
                    per_min_reg <= samp_bin_reg;
                end
                if (samp_bin_reg > per_max_reg)
                begin
                    per_max_reg <= samp_bin_reg;
                end
                if (samp_bin_reg < tot_min_reg)
                begin
                    tot_min_reg <= samp_bin_reg;
                end
                if (samp_bin_reg > tot_max_reg)
                begin
                    tot_max_reg <= samp_bin_reg;
                end
                smp_cnt_reg <= smp_cnt_inc;
                notice_reg  <= (smp_cnt_inc >= log_thresh_reg);
            end
            else if (do_finish)
            begin
                per_min_reg <= top_bin;
                per_max_reg <= '0;
                smp_cnt_reg <= '0;
            end
        end
    end

    // dump walk and pending record
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            walk_idx_reg <= '0;
            walk_hi_reg  <= '0;
            rd_idx_reg   <= '0;
            pend_vld_reg <= 1'b0;
            pend_idx_reg <= '0;
            pend_cnt_reg <= '0;
        end
        else if (go)
        begin
            unique case (ctrl.act)
                ACT_WALK_INIT:
                begin
                    walk_idx_reg <= {1'b0, dump_cum_reg ? tot_min_reg : per_min_reg};
                    walk_hi_reg  <= dump_cum_reg ? tot_max_reg : per_max_reg;
                    pend_vld_reg <= 1'b0;
                end
                ACT_WALK_STEP:
                begin
                    if (!walk_done)
                    begin
                        rd_idx_reg   <= walk_idx_reg[BIN_W-1:0];
                        walk_idx_reg <= walk_idx_reg + 1'b1;
                    end
                end
                ACT_PEND:
                begin
                    if (sel_nz)
                    begin
                        pend_vld_reg <= 1'b1;
                        pend_idx_reg <= rd_idx_reg;
                        pend_cnt_reg <= OUT_CNT_W'(sel_val);
                    end
                end
                ACT_FINISH:
                begin
                    pend_vld_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg  <= 1'b0;
            out_kind_reg <= KIND_NOTICE;
            out_idx_reg  <= '0;
            out_cnt_reg  <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            if (go && emit_req)
            begin
                out_vld_reg <= 1'b1;
                if (ctrl.act == ACT_NOTICE)
                begin
                    out_kind_reg <= KIND_NOTICE;
                    out_idx_reg  <= '0;
                    out_cnt_reg  <= '0;
                    out_last_reg <= 1'b1;
                end
                else
                begin
                    out_kind_reg <= KIND_RECORD;
                    out_idx_reg  <= IDX_W'(pend_idx_reg);
                    out_cnt_reg  <= pend_cnt_reg;
                    out_last_reg <= (ctrl.act == ACT_FINISH);
                end
            end
            else if (m_axis_tready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - OUT_CNT_W - IDX_W)'(0), out_cnt_reg, out_idx_reg};
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // no record is left pending once the block takes new input
    a_no_pend_at_fetch: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !pend_vld_reg)
        else $error("pending record left over at fetch");

    // the period ends with an empty table and a zero counter
    a_period_clear: assert property (@(posedge clk) disable iff (!rst_n)
        do_finish |=> (per_vld_reg == '0) && (smp_cnt_reg == '0))
        else $error("period not cleared after dump");

    // a period with samples has a proper min..max range
    a_min_le_max: assert property (@(posedge clk) disable iff (!rst_n)
        (smp_cnt_reg != '0) |-> (per_min_reg <= per_max_reg))
        else $error("period min bin above max bin");

    // a tested bin always lies inside the walked range
    a_walk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.act == ACT_PEND) |-> (rd_idx_reg <= walk_hi_reg))
        else $error("dump tested a bin beyond the range");

endmodule
